FILE: hw/rtl/mcu_mbox_pkg.sv
// shared types and codes for the host/mcu byte mailbox
package mcu_mbox_pkg;

    typedef logic [2:0] req_code_t;

    localparam req_code_t REQ_HOST_WRITE  = 3'd0;
    localparam req_code_t REQ_HOST_READ   = 3'd1;
    localparam req_code_t REQ_HOST_STATUS = 3'd2;
    localparam req_code_t REQ_PORT_WRITE  = 3'd3;
    localparam req_code_t REQ_PORT_READ   = 3'd4;

    localparam logic [1:0] PORT_0 = 2'd0;
    localparam logic [1:0] PORT_1 = 2'd1;
    localparam logic [1:0] PORT_2 = 2'd2;
    localparam logic [1:0] PORT_3 = 2'd3;

    localparam logic CFG_DIP_A = 1'b0;
    localparam logic CFG_DIP_B = 1'b1;

    localparam logic [7:0] IRQ_CLEAR_BYTE = 8'hff;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  port;
        logic [7:0]  data;
        logic [31:0] player_inputs;
    } mbox_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       mcu_irq;
        logic       sub_cpu_reset;
    } mbox_rsp_t;

endpackage

FILE: hw/rtl/mcu_host_mailbox_top.sv
// host/mcu byte mailbox: access register, state update and result register
//
// Usage: every beat on the s_ channel is one bus access (host data write,
// host data read, host status read, mcu port write or mcu port read). Each
// accepted beat produces exactly one beat on the m_ channel carrying the
// read byte (zero for writes), the mcu interrupt line and the sub-cpu reset
// line as they stand after the access.
// An accepted access is registered, then processed and its result put in
// the result register, which drives m_valid. Throughput is one access per
// cycle while the receiver does not stall; the state update for an access
// happens in the cycle it moves into the result register, so back-to-back
// accesses see each other in order. When the receiver stalls, the result
// register holds its beat and the access register holds one more; s_ready
// drops only when both are full. The dip switch banks are written through
// cfg_we / cfg_index / cfg_wdata (index 0 bank a, index 1 bank b); the user
// must write them only while no access is in flight, which the block does
// not enforce. Reset (aresetn low, synchronous) empties both registers and
// clears all latches, full flags, the interrupt flag and both output lines.
module mcu_host_mailbox_top
    import mcu_mbox_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  mbox_req_t s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output mbox_rsp_t m_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [7:0] cfg_wdata
);

    logic [7:0] dip_a_reg, dip_b_reg;
    logic [7:0] port0_reg, port0_next;
    logic [7:0] port1_reg, port1_next;
    logic [7:0] to_mcu_reg, to_mcu_next;
    logic [7:0] to_host_reg, to_host_next;
    logic       to_mcu_full_reg, to_mcu_full_next;
    logic       to_host_full_reg, to_host_full_next;
    logic       int_flag_reg, int_flag_next;
    logic       irq_reg, irq_next;
    logic       sub_rst_reg, sub_rst_next;

    mbox_req_t  req_reg;
    logic       req_valid_reg;
    mbox_rsp_t  rsp_reg, rsp_next;
    logic       rsp_valid_reg;

    logic       out_free;
    logic       advance;
    logic [1:0] sel;

    assign out_free = !rsp_valid_reg || m_ready;
    assign advance  = req_valid_reg && out_free;
    assign s_ready  = !req_valid_reg || out_free;
    assign m_valid  = rsp_valid_reg;
    assign m_data   = rsp_reg;

    always_comb begin
        port0_next        = port0_reg;
        port1_next        = port1_reg;
        to_mcu_next       = to_mcu_reg;
        to_host_next      = to_host_reg;
        to_mcu_full_next  = to_mcu_full_reg;
        to_host_full_next = to_host_full_reg;
        int_flag_next     = int_flag_reg;
        irq_next          = irq_reg;
        sub_rst_next      = sub_rst_reg;
        rsp_next.read_data = 8'd0;
        sel = 2'd0;
        case (req_reg.req_type)
            REQ_HOST_WRITE: begin
                to_mcu_next      = req_reg.data;
                to_mcu_full_next = 1'b1;
                int_flag_next    = 1'b0;
                irq_next         = 1'b1;
            end
            REQ_HOST_READ: begin
                to_host_full_next  = 1'b0;
                rsp_next.read_data = to_host_reg;
            end
            REQ_HOST_STATUS: begin
                rsp_next.read_data = {4'd0, to_mcu_full_reg, !to_host_full_reg, 2'd0};
            end
            REQ_PORT_WRITE: begin
                case (req_reg.port)
                    PORT_0: begin
                        // rising edge of bit 1 hands port 1 to the host
                        if (!port0_reg[1] && req_reg.data[1]) begin
                            to_host_full_next = 1'b1;
                            to_host_next      = port1_reg;
                        end
                        if (req_reg.data[0]) begin
                            to_mcu_full_next = 1'b0;
                        end
                        port0_next = req_reg.data;
                    end
                    PORT_1: begin
                        if (req_reg.data == IRQ_CLEAR_BYTE) begin
                            int_flag_next = 1'b1;
                            irq_next      = 1'b0;
                        end
                        port1_next = req_reg.data;
                    end
                    PORT_2: begin
                    end
                    default: begin
                        sub_rst_next = !req_reg.data[1];
                    end
                endcase
            end
            REQ_PORT_READ: begin
                case (req_reg.port)
                    PORT_0: begin
                        rsp_next.read_data = 8'd0;
                    end
                    PORT_1: begin
                        rsp_next.read_data = port0_reg[0] ? 8'd0 : to_mcu_reg;
                    end
                    PORT_2: begin
                        sel = port0_reg[3:2];
                        rsp_next.read_data = req_reg.player_inputs[{sel, 3'b000} +: 8];
                    end
                    default: begin
                        sel = port0_reg[6:5];
                        rsp_next.read_data = {dip_b_reg[{1'b1, sel}], dip_b_reg[{1'b0, sel}],
                                              dip_a_reg[{1'b1, sel}], dip_a_reg[{1'b0, sel}],
                                              to_host_full_reg, int_flag_reg, 2'd0};
                    end
                endcase
            end
            default: begin
            end
        endcase
        rsp_next.mcu_irq       = irq_next;
        rsp_next.sub_cpu_reset = sub_rst_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dip_a_reg        <= 8'd0;
            dip_b_reg        <= 8'd0;
            port0_reg        <= 8'd0;
            port1_reg        <= 8'd0;
            to_mcu_reg       <= 8'd0;
            to_host_reg      <= 8'd0;
            to_mcu_full_reg  <= 1'b0;
            to_host_full_reg <= 1'b0;
            int_flag_reg     <= 1'b0;
            irq_reg          <= 1'b0;
            sub_rst_reg      <= 1'b0;
            req_valid_reg    <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DIP_A: dip_a_reg <= cfg_wdata;
                    default:   dip_b_reg <= cfg_wdata;
                endcase
            end
            if (advance) begin
                port0_reg        <= port0_next;
                port1_reg        <= port1_next;
                to_mcu_reg       <= to_mcu_next;
                to_host_reg      <= to_host_next;
                to_mcu_full_reg  <= to_mcu_full_next;
                to_host_full_reg <= to_host_full_next;
                int_flag_reg     <= int_flag_next;
                irq_reg          <= irq_next;
                sub_rst_reg      <= sub_rst_next;
            end
            if (s_ready) begin
                req_valid_reg <= s_valid;
            end
            if (out_free) begin
                rsp_valid_reg <= req_valid_reg;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (advance) begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

FILE: test/tb.sv
// self-checking testbench for the host/mcu byte mailbox top level
module tb;
    import mcu_mbox_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    mbox_req_t  s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    mbox_rsp_t  m_data;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_DIP_A;
    logic [7:0] cfg_wdata = 8'h00;

    mcu_host_mailbox_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mailbox state as the predictor sees it
    logic [7:0] dip_a = 8'h00;
    logic [7:0] dip_b = 8'h00;
    logic [7:0] mb_port0 = 8'h00;
    logic [7:0] mb_port1 = 8'h00;
    logic [7:0] mb_to_mcu_byte = 8'h00;
    logic [7:0] mb_to_host_byte = 8'h00;
    logic       mb_to_mcu_full = 1'b0;
    logic       mb_to_host_full = 1'b0;
    logic       mb_int_flag = 1'b0;
    logic       mb_irq = 1'b0;
    logic       mb_sub_reset = 1'b0;

    mbox_req_t access_q[$];
    mbox_rsp_t rsp_expected[$];
    mbox_rsp_t predicted;
    mbox_rsp_t expected_rsp;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_go = 1'b0;
    int hold_left = 0;

    int n_pushed = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int input_stalls = 0;

    task automatic predict_access(input mbox_req_t a, output mbox_rsp_t r);
        logic [2:0] sel;
        r = '0;
        case (a.req_type)
            REQ_HOST_WRITE: begin
                mb_to_mcu_byte = a.data;
                mb_to_mcu_full = 1'b1;
                mb_int_flag    = 1'b0;
                mb_irq         = 1'b1;
            end
            REQ_HOST_READ: begin
                r.read_data     = mb_to_host_byte;
                mb_to_host_full = 1'b0;
            end
            REQ_HOST_STATUS: begin
                r.read_data = {4'b0000, mb_to_mcu_full, !mb_to_host_full, 2'b00};
            end
            REQ_PORT_WRITE: begin
                case (a.port)
                    PORT_0: begin
                        // handoff to the host on a rising edge of bit 1
                        if (!mb_port0[1] && a.data[1]) begin
                            mb_to_host_full = 1'b1;
                            mb_to_host_byte = mb_port1;
                        end
                        if (a.data[0])
                            mb_to_mcu_full = 1'b0;
                        mb_port0 = a.data;
                    end
                    PORT_1: begin
                        if (a.data == IRQ_CLEAR_BYTE) begin
                            mb_int_flag = 1'b1;
                            mb_irq      = 1'b0;
                        end
                        mb_port1 = a.data;
                    end
                    PORT_2: ;
                    default: mb_sub_reset = !a.data[1];
                endcase
            end
            REQ_PORT_READ: begin
                case (a.port)
                    PORT_0: r.read_data = 8'h00;
                    PORT_1: r.read_data = mb_port0[0] ? 8'h00 : mb_to_mcu_byte;
                    PORT_2: begin
                        sel = {1'b0, mb_port0[3:2]};
                        r.read_data = a.player_inputs[8*sel +: 8];
                    end
                    default: begin
                        sel = {1'b0, mb_port0[6:5]};
                        r.read_data = {dip_b[sel + 3'd4], dip_b[sel], dip_a[sel + 3'd4],
                                       dip_a[sel], mb_to_host_full, mb_int_flag, 2'b00};
                    end
                endcase
            end
            default: ;
        endcase
        r.mcu_irq       = mb_irq;
        r.sub_cpu_reset = mb_sub_reset;
    endtask

    task automatic report_mismatch(input string what, input mbox_rsp_t exp_rsp,
                                   input mbox_rsp_t got);
        n_errors++;
        if (n_errors <= 10)
            $display("%t mismatch (%s): expected rd=%02h irq=%b rst=%b, got rd=%02h irq=%b rst=%b",
                     $realtime, what, exp_rsp.read_data, exp_rsp.mcu_irq,
                     exp_rsp.sub_cpu_reset, got.read_data, got.mcu_irq, got.sub_cpu_reset);
    endtask

    // driver: one beat per accepted access, prediction in acceptance order
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_access(s_data, predicted);
                rsp_expected.push_back(predicted);
                n_accepted++;
            end
            if (s_valid && !s_ready) begin
                input_stalls++;
            end else if (access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= access_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge aclk) begin
        if (!aresetn)
            hold_left <= 0;
        else if (hold_go)
            hold_left <= 300;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rsp_expected.size() == 0) begin
                    report_mismatch("no result expected", '0, m_data);
                end else begin
                    expected_rsp = rsp_expected.pop_front();
                    if (m_data.read_data != expected_rsp.read_data ||
                        m_data.mcu_irq != expected_rsp.mcu_irq ||
                        m_data.sub_cpu_reset != expected_rsp.sub_cpu_reset)
                        report_mismatch("field", expected_rsp, m_data);
                    n_checked++;
                end
            end
            m_ready <= !hold_go && hold_left == 0 &&
                       $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'hff;
            1: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_access(input req_code_t t, input logic [1:0] p, input logic [7:0] d);
        mbox_req_t a;
        a.req_type      = t;
        a.port          = p;
        a.data          = d;
        a.player_inputs = $urandom;
        access_q.push_back(a);
        n_pushed++;
    endtask

    task automatic push_random_group();
        req_code_t t;
        case ($urandom_range(0, 9))
            0, 1: begin
                // host hands a byte to the mcu, mcu acks and drops its interrupt
                push_access(REQ_HOST_WRITE, 2'($urandom), rand_byte());
                push_access(REQ_HOST_STATUS, 2'($urandom), rand_byte());
                push_access(REQ_PORT_READ, PORT_1, rand_byte());
                push_access(REQ_PORT_WRITE, PORT_0, rand_byte() | 8'h01);
                push_access(REQ_PORT_READ, PORT_3, rand_byte());
                push_access(REQ_PORT_WRITE, PORT_1, IRQ_CLEAR_BYTE);
            end
            2, 3: begin
                // mcu hands a byte to the host via a bit 1 edge
                push_access(REQ_PORT_WRITE, PORT_1, rand_byte());
                push_access(REQ_PORT_WRITE, PORT_0, rand_byte() & 8'hfd);
                push_access(REQ_PORT_WRITE, PORT_0, rand_byte() | 8'h02);
                push_access(REQ_HOST_STATUS, 2'($urandom), rand_byte());
                push_access(REQ_PORT_READ, PORT_3, rand_byte());
                push_access(REQ_HOST_READ, 2'($urandom), rand_byte());
                push_access(REQ_HOST_STATUS, 2'($urandom), rand_byte());
            end
            4: begin
                push_access(REQ_PORT_WRITE, PORT_0, rand_byte());
                push_access(REQ_PORT_READ, PORT_2, rand_byte());
                push_access(REQ_PORT_READ, PORT_3, rand_byte());
                push_access(REQ_PORT_READ, PORT_1, rand_byte());
            end
            5: push_access(REQ_PORT_WRITE, PORT_3, rand_byte());
            default: begin
                if ($urandom_range(0, 9) == 0)
                    t = req_code_t'(REQ_PORT_READ + 3'($urandom_range(1, 3)));
                else
                    t = req_code_t'($urandom_range(REQ_HOST_WRITE, REQ_PORT_READ));
                push_access(t, 2'($urandom), rand_byte());
            end
        endcase
    endtask

    task automatic write_dip(input logic idx, input logic [7:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_DIP_A)
            dip_a = v;
        else
            dip_b = v;
    endtask

    task automatic wait_drained();
        while (n_checked != n_pushed)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [7:0] a, input logic [7:0] b, input int send_pct,
                             input int stall_pct, input int n, input bit with_hold);
        int target;
        wait_drained();
        write_dip(CFG_DIP_A, a);
        write_dip(CFG_DIP_B, b);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        if (with_hold)
            hold_go = 1'b1;
        target = n_pushed + n;
        while (n_pushed < target)
            push_random_group();
        if (with_hold) begin
            repeat (2) @(posedge aclk);
            hold_go = 1'b0;
        end
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part at reset dip values
        push_access(REQ_HOST_STATUS, PORT_0, 8'h00);
        push_access(REQ_HOST_WRITE, PORT_0, 8'h00);
        push_access(REQ_HOST_STATUS, PORT_3, 8'hff);
        push_access(REQ_PORT_READ, PORT_1, 8'h00);
        push_access(REQ_HOST_WRITE, PORT_2, 8'hff);
        push_access(REQ_PORT_READ, PORT_1, 8'h00);
        push_access(REQ_PORT_WRITE, PORT_0, 8'h01);
        push_access(REQ_PORT_READ, PORT_1, 8'h00);
        push_access(REQ_PORT_WRITE, PORT_1, IRQ_CLEAR_BYTE);
        push_access(REQ_PORT_READ, PORT_3, 8'h00);
        push_access(REQ_PORT_WRITE, PORT_1, 8'ha5);
        push_access(REQ_PORT_WRITE, PORT_0, 8'h02);
        push_access(REQ_HOST_STATUS, PORT_0, 8'h00);
        push_access(REQ_PORT_WRITE, PORT_0, 8'h02);
        push_access(REQ_HOST_READ, PORT_1, 8'h00);
        push_access(REQ_HOST_READ, PORT_0, 8'hff);
        push_access(REQ_PORT_WRITE, PORT_0, 8'hfc);
        push_access(REQ_PORT_READ, PORT_2, 8'h00);
        push_access(REQ_PORT_READ, PORT_3, 8'h00);
        push_access(REQ_PORT_WRITE, PORT_2, 8'hff);
        push_access(REQ_PORT_WRITE, PORT_3, 8'h00);
        push_access(REQ_PORT_WRITE, PORT_3, 8'hff);
        push_access(REQ_PORT_READ, PORT_0, 8'hff);
        for (int k = 1; k <= 3; k++)
            push_access(req_code_t'(REQ_PORT_READ + 3'(k)), 2'(k), 8'hff);

        run_phase(8'hff, 8'hff, 0, 0, 200, 1'b0);
        run_phase(8'h55, 8'haa, 60, 0, 200, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 0, 60, 200, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 24, 24, 200, 1'b0);
        run_phase(8'h00, 8'hff, 0, 0, 150, 1'b1);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (rsp_expected.size() != 0)
            report_mismatch("result never arrived", rsp_expected[0], '0);
        $display("covered %0d accesses over six dip/idle settings, %0d results checked",
                 n_accepted, n_checked);
        $display("input held off for %0d cycles, %0d mismatches", input_stalls, n_errors);
        if (n_errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #4000000;
        $display("timeout after %0d of %0d results", n_checked, n_pushed);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
